>>> sv/stk_pkg.sv
package stk_pkg;

    localparam int MAX_TOKEN = 1024;   // default longest token piece
    localparam int RES_MAX   = 4;      // results one byte can cause
    localparam int QDEPTH    = 4;      // bundles held between front and back

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_EOL  = 2'd2,
        K_EOT  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] ch;
        logic       quoted;
    } t_res;

    // results of one input byte, slot 0 first
    typedef struct packed {
        logic [2:0]             cnt;
        t_res [RES_MAX-1:0]     res;
    } t_bundle;

endpackage

>>> sv/stk_front.sv
module stk_front #(
    parameter int P_MAX_TOKEN = stk_pkg::MAX_TOKEN
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_byte,
    input  logic               i_eot,
    input  logic               i_full,
    output logic               o_push,
    output stk_pkg::t_bundle   o_bundle
);

    localparam int LIMIT = (P_MAX_TOKEN < 2) ? 2 : P_MAX_TOKEN;
    localparam int LEN_W = $clog2(LIMIT + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SLASH = 7'b0000010,
        S_LINE  = 7'b0000100,
        S_BLOCK = 7'b0001000,
        S_BSTAR = 7'b0010000,
        S_WORD  = 7'b0100000,
        S_QUOTE = 7'b1000000
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [LEN_W-1:0]   r_len, n_len;
    logic               r_cross;
    stk_pkg::t_bundle   n_bundle;
    logic               w_accept;

    function automatic stk_pkg::t_bundle f_put(stk_pkg::t_bundle bi, stk_pkg::t_kind k,
                                               logic [7:0] ch, logic q);
        stk_pkg::t_bundle bo;
        bo = bi;
        if (bi.cnt < 3'(stk_pkg::RES_MAX)) begin
            bo.res[bi.cnt[1:0]].kind   = k;
            bo.res[bi.cnt[1:0]].ch     = (k == stk_pkg::K_BYTE) ? ch : 8'd0;
            bo.res[bi.cnt[1:0]].quoted = q;
            bo.cnt = bi.cnt + 3'd1;
        end
        return bo;
    endfunction

    // token byte, with a cut when the piece is already full
    function automatic stk_pkg::t_bundle f_add(stk_pkg::t_bundle bi,
                                               inout logic [LEN_W-1:0] len,
                                               input logic [7:0] ch, input logic q);
        stk_pkg::t_bundle bo;
        bo = bi;
        if (len >= LEN_W'(LIMIT)) begin
            bo  = f_put(bo, stk_pkg::K_END, 8'd0, q);
            len = '0;
        end
        bo  = f_put(bo, stk_pkg::K_BYTE, ch, q);
        len = len + LEN_W'(1);
        return bo;
    endfunction

    always_comb begin
        t_mode              m;
        logic [LEN_W-1:0]   len;
        stk_pkg::t_bundle   bd;
        logic               done;
        logic               sep;
        m    = r_mode;
        len  = r_len;
        bd   = '0;
        done = 1'b0;
        sep  = (i_byte == stk_pkg::CH_SP) || (i_byte == stk_pkg::CH_LF)
            || (i_byte == stk_pkg::CH_CR);

        if (m == S_SLASH) begin
            if (i_byte == stk_pkg::CH_SLASH) begin
                m = S_LINE; done = 1'b1;
            end else if (i_byte == stk_pkg::CH_STAR) begin
                m = S_BLOCK; done = 1'b1;
            end else begin
                m   = S_WORD;
                len = '0;
                bd  = f_add(bd, len, stk_pkg::CH_SLASH, 1'b0);
            end
        end
        if (!done && m == S_LINE) begin
            if (i_byte != stk_pkg::CH_LF) done = 1'b1;
            else m = S_IDLE;
        end
        if (!done && m == S_BLOCK) begin
            if (i_byte == stk_pkg::CH_STAR) m = S_BSTAR;
            done = 1'b1;
        end
        if (!done && m == S_BSTAR) begin
            if (i_byte == stk_pkg::CH_SLASH) m = S_IDLE;
            else if (i_byte != stk_pkg::CH_STAR) m = S_BLOCK;
            done = 1'b1;
        end
        if (!done && m == S_WORD) begin
            if (sep) begin
                bd = f_put(bd, stk_pkg::K_END, 8'd0, 1'b0);
                m  = S_IDLE;
            end else begin
                bd   = f_add(bd, len, i_byte, 1'b0);
                done = 1'b1;
            end
        end
        if (!done && m == S_QUOTE) begin
            if (i_byte == stk_pkg::CH_QUOTE) begin
                m  = S_IDLE;
                bd = f_put(bd, stk_pkg::K_END, 8'd0, 1'b1);
            end else begin
                bd = f_add(bd, len, i_byte, 1'b1);
            end
            done = 1'b1;
        end
        // idle, after a word or line comment has ended on this byte, or any stray code
        if (!done) begin
            m = S_IDLE;
            if (i_byte == stk_pkg::CH_SP || i_byte == stk_pkg::CH_CR) begin
                // separator, nothing to do
            end else if (i_byte == stk_pkg::CH_LF) begin
                if (!r_cross) bd = f_put(bd, stk_pkg::K_EOL, 8'd0, 1'b0);
            end else if (i_byte == stk_pkg::CH_SLASH) begin
                m = S_SLASH;
            end else if (i_byte == stk_pkg::CH_QUOTE) begin
                len = '0;
                m   = S_QUOTE;
            end else begin
                len = '0;
                m   = S_WORD;
                bd  = f_add(bd, len, i_byte, 1'b0);
            end
        end

        if (i_eot) begin
            if (m == S_SLASH) begin
                m   = S_WORD;
                len = '0;
                bd  = f_add(bd, len, stk_pkg::CH_SLASH, 1'b0);
            end
            if (m == S_WORD) bd = f_put(bd, stk_pkg::K_END, 8'd0, 1'b0);
            else if (m == S_QUOTE) bd = f_put(bd, stk_pkg::K_END, 8'd0, 1'b1);
            bd  = f_put(bd, stk_pkg::K_EOT, 8'd0, 1'b0);
            m   = S_IDLE;
            len = '0;
        end

        n_mode   = m;
        n_len    = len;
        n_bundle = bd;
    end

    assign o_ready  = !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && (n_bundle.cnt != 3'd0);
    assign o_bundle = n_bundle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_IDLE;
            r_len   <= '0;
            r_cross <= 1'b1;
        end else begin
            if (w_accept) begin
                r_mode <= n_mode;
                r_len  <= n_len;
            end
            if (i_cfg_we) r_cross <= i_cfg_wdata;
        end
    end

    a_eot_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_eot) |-> (o_push
            && n_bundle.res[n_bundle.cnt[1:0] - 2'd1].kind == stk_pkg::K_EOT))
        else $error("end of text not closing its bundle");

    a_eot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_eot) |=> (r_mode == S_IDLE && r_len == '0))
        else $error("scan state not cleared after end of text");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (n_len <= LEN_W'(LIMIT)))
        else $error("token length beyond limit");

endmodule

>>> sv/stk_queue.sv
module stk_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  stk_pkg::t_bundle   i_bundle,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_valid,
    output stk_pkg::t_bundle   o_head
);

    localparam int A_W = $clog2(stk_pkg::QDEPTH);

    stk_pkg::t_bundle       r_mem [stk_pkg::QDEPTH];
    logic [A_W-1:0]         r_wp, r_rp;
    logic [A_W:0]           r_cnt;

    assign o_full  = (r_cnt == (A_W+1)'(stk_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_bundle;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + A_W'(1);
            if (i_pop)  r_rp <= r_rp + A_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (A_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (A_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("bundle queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("bundle queue underflow");

    a_nonempty_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (i_bundle.cnt != 3'd0 && i_bundle.cnt <= 3'(stk_pkg::RES_MAX)))
        else $error("bundle with bad result count");

endmodule

>>> sv/stk_back.sv
module stk_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  stk_pkg::t_bundle   i_head,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [7:0]         o_tdata,
    output logic [2:0]         o_tuser,
    output logic               o_tlast
);

    logic [1:0]     r_idx;
    logic           w_last;
    logic           w_fire;
    stk_pkg::t_res  w_res;

    assign w_res    = i_head.res[r_idx];
    assign w_last   = ({1'b0, r_idx} == (i_head.cnt - 3'd1));
    assign w_fire   = i_valid && i_tready;
    assign o_pop    = w_fire && w_last;
    assign o_tvalid = i_valid;
    assign o_tdata  = w_res.ch;
    assign o_tuser  = {w_res.quoted, w_res.kind};
    assign o_tlast  = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_fire) begin
            r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    a_idx_in_bundle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ({1'b0, r_idx} < i_head.cnt))
        else $error("result index past end of bundle");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_idx == 2'd0))
        else $error("result index not rewound after bundle");

endmodule

>>> sv/script_tokenizer_with_comments.sv
// Script tokenizer with comment skipping. Text enters one byte per transaction on the
// s_axis side (tlast marks the final byte of the text) and leaves as a stream of
// results on the m_axis side: token bytes, token ends, end-of-line marks and one
// end-of-text mark. Space, CR and LF separate tokens; "//" and "/* */" comments are
// dropped; a double-quoted string is one token without its quotes. m_axis_tlast marks
// the last result caused by an input byte; bytes that cause nothing (separators,
// comment text) give no transaction. The classifier takes one byte every cycle while the
// queue is not full and posts its results, up to four, as one bundle into a four-entry
// queue; the output side plays out one result per cycle while m_axis_tready is high, so
// sustained throughput is one byte per cycle while bytes average no more than one result.
// cross_lines (reset 1) is written via i_cfg_we; the user must write it only while the
// stream is idle. 0 turns an LF outside a token into an end-of-line result. Tokens longer
// than P_MAX_TOKEN (or than 2, if that is larger) are cut and carry on.
module script_tokenizer_with_comments #(
    parameter int P_MAX_TOKEN = stk_pkg::MAX_TOKEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: cross_lines
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // input bytes
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] byte_value
    input  logic        s_axis_tlast,    // end_of_text
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] token_byte
    output logic [2:0]  m_axis_tuser,    // [1:0] result_kind, [2] was_quoted
    output logic        m_axis_tlast     // last_of_run
);

    logic               w_push;
    logic               w_full;
    logic               w_pop;
    logic               w_qvalid;
    stk_pkg::t_bundle   w_in_bundle;
    stk_pkg::t_bundle   w_head;

    // front: mode tracking, comment skipping, token cutting
    stk_front #(
        .P_MAX_TOKEN (P_MAX_TOKEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_eot       (s_axis_tlast),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_bundle    (w_in_bundle)
    );

    // result bundles waiting for the output side
    stk_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_bundle (w_in_bundle),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_valid  (w_qvalid),
        .o_head   (w_head)
    );

    // back: one result per transaction
    stk_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qvalid),
        .i_head   (w_head),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

endmodule

>>> dv/script_tokenizer_with_comments_checker.sv
module script_tokenizer_with_comments_checker #(
    parameter int P_MAX_TOKEN = stk_pkg::MAX_TOKEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_data,     // [7:0] byte_value
    input  logic       i_in_last,     // end_of_text
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_data,    // [7:0] token_byte
    input  logic [2:0] i_out_user,    // [1:0] result_kind, [2] was_quoted
    input  logic       i_out_last,    // last_of_run
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        SM_IDLE, SM_SLASH, SM_LINE, SM_BLOCK, SM_BSTAR, SM_WORD, SM_QUOTE
    } t_scan;

    typedef struct packed {
        stk_pkg::t_res res;
        logic          last;
    } t_expect;

    // a cap below 2 behaves as 2
    localparam int PIECE_CAP = (P_MAX_TOKEN < 2) ? 2 : P_MAX_TOKEN;

    logic          cross_lines;
    t_scan         scan;
    int            piece_len;
    stk_pkg::t_res step_res[$];
    t_expect       tokens_due[$];

    function automatic void post_result(input stk_pkg::t_kind kind, input logic [7:0] ch,
                                        input logic quoted);
        stk_pkg::t_res r;
        r.kind   = kind;
        r.ch     = (kind == stk_pkg::K_BYTE) ? ch : 8'h00;
        r.quoted = quoted;
        step_res.push_back(r);
    endfunction

    function automatic void append_char(input logic [7:0] ch, input logic quoted);
        if (piece_len >= PIECE_CAP) begin
            post_result(stk_pkg::K_END, 8'h00, quoted);
            piece_len = 0;
        end
        post_result(stk_pkg::K_BYTE, ch, quoted);
        piece_len++;
    endfunction

    function automatic bit is_sep(input logic [7:0] b);
        return b == stk_pkg::CH_SP || b == stk_pkg::CH_LF || b == stk_pkg::CH_CR;
    endfunction

    function automatic void scan_char(input logic [7:0] b);
        bit again;
        again = 1'b1;
        while (again) begin
            again = 1'b0;
            case (scan)
                SM_SLASH: begin
                    if (b == stk_pkg::CH_SLASH) begin
                        scan = SM_LINE;
                    end else if (b == stk_pkg::CH_STAR) begin
                        scan = SM_BLOCK;
                    end else begin
                        scan = SM_WORD;
                        piece_len = 0;
                        append_char(stk_pkg::CH_SLASH, 1'b0);
                        again = 1'b1;
                    end
                end
                SM_LINE: begin
                    if (b == stk_pkg::CH_LF) begin
                        scan = SM_IDLE;
                        again = 1'b1;
                    end
                end
                SM_BLOCK: begin
                    if (b == stk_pkg::CH_STAR) scan = SM_BSTAR;
                end
                SM_BSTAR: begin
                    if (b == stk_pkg::CH_SLASH) scan = SM_IDLE;
                    else if (b != stk_pkg::CH_STAR) scan = SM_BLOCK;
                end
                SM_WORD: begin
                    if (is_sep(b)) begin
                        post_result(stk_pkg::K_END, 8'h00, 1'b0);
                        scan = SM_IDLE;
                        again = 1'b1;
                    end else begin
                        append_char(b, 1'b0);
                    end
                end
                SM_QUOTE: begin
                    if (b == stk_pkg::CH_QUOTE) begin
                        scan = SM_IDLE;
                        post_result(stk_pkg::K_END, 8'h00, 1'b1);
                    end else begin
                        append_char(b, 1'b1);
                    end
                end
                default: begin
                    scan = SM_IDLE;
                    if (b == stk_pkg::CH_LF) begin
                        if (!cross_lines) post_result(stk_pkg::K_EOL, 8'h00, 1'b0);
                    end else if (b == stk_pkg::CH_SLASH) begin
                        scan = SM_SLASH;
                    end else if (b != stk_pkg::CH_SP && b != stk_pkg::CH_CR) begin
                        piece_len = 0;
                        if (b == stk_pkg::CH_QUOTE) begin
                            scan = SM_QUOTE;
                        end else begin
                            scan = SM_WORD;
                            append_char(b, 1'b0);
                        end
                    end
                end
            endcase
        end
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input logic eot);
        t_expect e;
        step_res.delete();
        scan_char(b);
        if (eot) begin
            if (scan == SM_SLASH) begin
                scan = SM_WORD;
                piece_len = 0;
                append_char(stk_pkg::CH_SLASH, 1'b0);
            end
            if (scan == SM_WORD) post_result(stk_pkg::K_END, 8'h00, 1'b0);
            else if (scan == SM_QUOTE) post_result(stk_pkg::K_END, 8'h00, 1'b1);
            post_result(stk_pkg::K_EOT, 8'h00, 1'b0);
            scan = SM_IDLE;
            piece_len = 0;
        end
        foreach (step_res[i]) begin
            e.res  = step_res[i];
            e.last = (i == step_res.size() - 1);
            tokens_due.push_back(e);
        end
    endfunction

    always @(posedge i_clk) begin
        t_expect want;
        if (!i_rst_n) begin
            cross_lines = 1'b1;
            scan = SM_IDLE;
            piece_len = 0;
            tokens_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (tokens_due.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: expected nothing, got k%0d b%02h q%0b l%0b", $time,
                             i_out_user[1:0], i_out_data, i_out_user[2], i_out_last);
                end else begin
                    want = tokens_due.pop_front();
                    if ({i_out_user, i_out_data, i_out_last} !==
                        {want.res.quoted, want.res.kind, want.res.ch, want.last}) begin
                        o_fail_count++;
                        $display("%0t: expected k%0d b%02h q%0b l%0b, got k%0d b%02h q%0b l%0b",
                                 $time, want.res.kind, want.res.ch, want.res.quoted, want.last,
                                 i_out_user[1:0], i_out_data, i_out_user[2], i_out_last);
                    end
                end
            end
            if (i_cfg_we) cross_lines = i_cfg_wdata;
            if (i_in_valid && i_in_ready) tokenize_byte(i_in_data, i_in_last);
        end
        o_pending = tokens_due.size();
    end

endmodule

>>> dv/script_tokenizer_with_comments_test.sv
module script_tokenizer_with_comments_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Default cap on token pieces.
    localparam int TOKEN_CAP    = stk_pkg::MAX_TOKEN;
    localparam int HOLD_CYCLES  = 80;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 10;   // covers the queue plus a byte in flight
    localparam int PHASE_ITEMS  = 70;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // [7:0] byte_value
    logic       s_tlast;     // end_of_text
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // [7:0] token_byte
    logic [2:0] m_tuser;     // [1:0] result_kind, [2] was_quoted
    logic       m_tlast;     // last_of_run

    int         fails;
    int         pending;
    int         sent;        // accepted input transactions
    bit         hold_req;    // asks the receiver for one long hold-off
    bit         steady;      // no idling on either side
    logic [7:0] text_buf[$];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    script_tokenizer_with_comments #(
        .P_MAX_TOKEN(TOKEN_CAP)
    ) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .s_axis_tvalid(s_tvalid),
        .s_axis_tready(s_tready),
        .s_axis_tdata (s_tdata),
        .s_axis_tlast (s_tlast),
        .m_axis_tvalid(m_tvalid),
        .m_axis_tready(m_tready),
        .m_axis_tdata (m_tdata),
        .m_axis_tuser (m_tuser),
        .m_axis_tlast (m_tlast)
    );

    script_tokenizer_with_comments_checker #(
        .P_MAX_TOKEN(TOKEN_CAP)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (s_tvalid),
        .i_in_ready  (s_tready),
        .i_in_data   (s_tdata),
        .i_in_last   (s_tlast),
        .i_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_out_data  (m_tdata),
        .i_out_user  (m_tuser),
        .i_out_last  (m_tlast),
        .o_fail_count(fails),
        .o_pending   (pending)
    );

    // Idle lengths: mostly none, else a random gap, now and then a long one.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(0, 2))
            0: return stk_pkg::CH_SP;
            1: return stk_pkg::CH_CR;
            default: return stk_pkg::CH_LF;
        endcase
    endfunction

    // Token characters: mostly printable (quote, slash and star among them),
    // some tabs, some anything at all.
    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 8'($urandom_range(8'h21, 8'h7E));
        if (r == 7) return 8'h09;
        return 8'($urandom_range(0, 255));
    endfunction

    // One text of script-like pieces: words, strings, both comment styles, lone
    // slashes, separators and raw noise. Closers go missing now and then, so
    // strings and comments also run into the end of the text.
    function automatic void build_text();
        int pieces;
        int len;
        logic [7:0] c;
        text_buf.delete();
        pieces = $urandom_range(1, 4);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    len = $urandom_range(1, 5);
                    repeat (len) text_buf.push_back(word_char());
                end
                3, 4: begin
                    text_buf.push_back(stk_pkg::CH_QUOTE);
                    len = $urandom_range(0, 4);
                    repeat (len) begin
                        c = ($urandom_range(0, 4) == 0) ? sep_char() : word_char();
                        if (c == stk_pkg::CH_QUOTE) c = 8'h51;
                        text_buf.push_back(c);
                    end
                    if ($urandom_range(0, 5) != 0) text_buf.push_back(stk_pkg::CH_QUOTE);
                end
                5: begin
                    text_buf.push_back(stk_pkg::CH_SLASH);
                    text_buf.push_back(stk_pkg::CH_SLASH);
                    len = $urandom_range(0, 4);
                    repeat (len) begin
                        c = word_char();
                        if (c == stk_pkg::CH_LF) c = 8'h23;
                        text_buf.push_back(c);
                    end
                    if ($urandom_range(0, 5) != 0) text_buf.push_back(stk_pkg::CH_LF);
                end
                6: begin
                    text_buf.push_back(stk_pkg::CH_SLASH);
                    text_buf.push_back(stk_pkg::CH_STAR);
                    len = $urandom_range(0, 5);
                    repeat (len) begin
                        case ($urandom_range(0, 4))
                            0: c = stk_pkg::CH_STAR;
                            1: c = stk_pkg::CH_SLASH;
                            2: c = sep_char();
                            default: c = word_char();
                        endcase
                        text_buf.push_back(c);
                    end
                    if ($urandom_range(0, 5) != 0) begin
                        text_buf.push_back(stk_pkg::CH_STAR);
                        text_buf.push_back(stk_pkg::CH_SLASH);
                    end
                end
                7: begin
                    text_buf.push_back(stk_pkg::CH_SLASH);
                    if ($urandom_range(0, 1) != 0) text_buf.push_back(word_char());
                end
                8: begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_buf.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    len = $urandom_range(1, 3);
                    repeat (len) text_buf.push_back(sep_char());
                end
            endcase
            // pieces mostly apart; glued ones put slashes and quotes mid-token
            if ($urandom_range(0, 7) != 0) text_buf.push_back(sep_char());
        end
    endfunction

    // One input transaction, then perhaps an idle gap. tvalid stays high into
    // the next call when there is no gap, so it is never dropped and raised
    // within the same time step.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], eot && (i == s.len() - 1));
    endtask

    // Stop offering, let every expected result arrive, then allow DRAIN_CYCLES more
    // for bytes that give no result.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_cross(input logic v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Receiver: random back-pressure, plus one long hold-off on request so that
    // the result queue fills and the input side has to stall.
    initial begin
        int stall;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(0, 7)) @(posedge clk);
                end else begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    initial begin
        int goal;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        s_tlast   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, cross_lines at its reset value: zero and all-ones bytes in
        // one token, lone slash starting a token, slash and quote inside a
        // token, a quoted token, an empty string, a line comment closed by LF
        // and a block comment with a star before the close.
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(stk_pkg::CH_SP, 1'b0);
        send_text("/x/\"", 1'b0);
        send_byte(stk_pkg::CH_CR, 1'b0);
        send_text("\"abc\"\"\"", 1'b0);
        send_text("//z\n/**q*/", 1'b0);

        // Line mode: LF after a token ends it and then reports end of line;
        // unterminated string at end of text; lone slash flushed with a
        // following byte at end of text (four results); slash alone at the end.
        write_cross(1'b0);
        send_text("a\n", 1'b0);
        send_text("\"k", 1'b1);
        send_text("/x", 1'b1);
        send_text("/", 1'b1);

        // Random texts in phases, the register flipping between them. Phase 1
        // carries the long receiver hold-off, phase 3 runs with no idling.
        for (int phase = 0; phase < 4; phase++) begin
            write_cross((phase % 2) == 1);
            steady = (phase == 3);
            if (phase == 1) hold_req = 1'b1;
            goal = sent + PHASE_ITEMS;
            while (sent < goal) begin
                build_text();
                foreach (text_buf[i]) send_byte(text_buf[i], i == text_buf.size() - 1);
            end
            settle();
        end

        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> script_tokenizer_with_comments.f
sv/stk_pkg.sv
sv/stk_front.sv
sv/stk_queue.sv
sv/stk_back.sv
sv/script_tokenizer_with_comments.sv
dv/script_tokenizer_with_comments_checker.sv
dv/script_tokenizer_with_comments_test.sv
